@@ src/mlu_pkg.sv @@
// ----------------------------------------------------------------------------
// mlu_pkg
// Shared types, constants and decode functions for the mu-law/PCM clip
// upsampler.
// ----------------------------------------------------------------------------
package mlu_pkg;

    localparam int BLOCK_SAMPLES = 128;
    localparam int BBC_W         = $clog2(2 * BLOCK_SAMPLES + 1);
    localparam int LEN_W         = 24;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_STOP = 1'b1;

    localparam logic [1:0] HDR_LEN0 = 2'd0;
    localparam logic [1:0] HDR_LEN1 = 2'd1;
    localparam logic [1:0] HDR_LEN2 = 2'd2;
    localparam logic [1:0] HDR_FMT  = 2'd3;

    localparam logic [1:0] RFL_1X = 2'd0;
    localparam logic [1:0] RFL_2X = 2'd1;
    localparam logic [1:0] RFL_4X = 2'd2;

    // output sample kinds within one item's burst
    localparam logic [1:0] KIND_Q1  = 2'd0;
    localparam logic [1:0] KIND_MID = 2'd1;
    localparam logic [1:0] KIND_Q3  = 2'd2;
    localparam logic [1:0] KIND_CUR = 2'd3;

    typedef struct packed {
        logic signed [15:0] prior;
        logic signed [15:0] cur;
        logic [1:0]         rfl;
        logic               last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [15:0] mulaw_decode(input logic [7:0] code);
        logic [7:0]  u;
        logic [2:0]  ex;
        logic [3:0]  mant;
        logic [15:0] mag;
        u    = ~code;
        ex   = u[6:4];
        mant = u[3:0];
        mag  = (({9'd0, mant, 3'd0} + 16'h0084) << ex) - 16'h0084;
        return $signed(u[7] ? (16'd0 - mag) : mag);
    endfunction

    function automatic logic [BBC_W-1:0] block_bytes(input logic pcm,
                                                     input logic [1:0] rfl);
        logic [BBC_W-1:0] per;
        per = BBC_W'(BLOCK_SAMPLES) >> rfl;
        return pcm ? (per << 1) : per;
    endfunction

endpackage

@@ src/mlu_front.sv @@
// ----------------------------------------------------------------------------
// mlu_front
// Byte front end: header parsing, sample decode, block length accounting.
// Emits one job per decoded sample into the job queue.
// ----------------------------------------------------------------------------
module mlu_front
    import mlu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       full,
    input  q_stat_t    q_stat,
    output logic       job_push,
    output job_t       job
);

    logic               phase_reg, phase_next;
    logic [1:0]         hidx_reg, hidx_next;
    logic               is_pcm_reg, is_pcm_next;
    logic [1:0]         rfl_reg, rfl_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [BBC_W-1:0]   bbc_reg, bbc_next;
    logic signed [15:0] prior_reg, prior_next;
    logic [7:0]         low_reg, low_next;
    logic               held_reg, held_next;

    logic               accept;
    logic [BBC_W-1:0]   consumed;
    logic [BBC_W-1:0]   bbc_inc;
    logic [LEN_W-1:0]   consumed_ext;
    logic signed [15:0] cur;
    logic               fmt_ok;

    assign full         = q_stat.full;
    assign accept       = push && !q_stat.full;
    assign consumed     = block_bytes(is_pcm_reg, rfl_reg);
    assign consumed_ext = {{(LEN_W - BBC_W){1'b0}}, consumed};
    assign bbc_inc      = bbc_reg + 1'b1;
    assign cur          = is_pcm_reg ? $signed({data_byte, low_reg}) : mulaw_decode(data_byte);
    assign fmt_ok       = (data_byte[6:2] == 5'd0) && (data_byte[1:0] != 2'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        is_pcm_next = is_pcm_reg;
        rfl_next    = rfl_reg;
        rem_next    = rem_reg;
        bbc_next    = bbc_reg;
        prior_next  = prior_reg;
        low_next    = low_reg;
        held_next   = held_reg;
        job_push    = 1'b0;
        job.prior   = prior_reg;
        job.cur     = cur;
        job.rfl     = rfl_reg;
        job.last    = 1'b0;

        if (accept)
        begin
            if (op == OP_STOP)
            begin
                phase_next = 1'b0;
                hidx_next  = HDR_LEN0;
            end
            else if (!phase_reg)
            begin
                case (hidx_reg)
                    HDR_LEN0: rem_next = {16'd0, data_byte};
                    HDR_LEN1: rem_next = rem_reg | {8'd0, data_byte, 8'd0};
                    HDR_LEN2: rem_next = rem_reg | {data_byte, 16'd0};
                    HDR_FMT:
                    begin
                        if (fmt_ok)
                        begin
                            phase_next  = 1'b1;
                            is_pcm_next = data_byte[7];
                            rfl_next    = data_byte[1:0] - 2'd1;
                            prior_next  = 16'sd0;
                            bbc_next    = '0;
                            held_next   = 1'b0;
                            low_next    = 8'd0;
                        end
                    end
                    default: rem_next = rem_reg;
                endcase
                hidx_next = hidx_reg + 2'd1;
            end
            else if (is_pcm_reg && !held_reg)
            begin
                low_next  = data_byte;
                held_next = 1'b1;
                bbc_next  = bbc_inc;
            end
            else
            begin
                held_next  = 1'b0;
                prior_next = cur;
                job_push   = 1'b1;
                if (bbc_inc >= consumed)
                begin
                    bbc_next = '0;
                    if (rem_reg > consumed_ext)
                    begin
                        rem_next = rem_reg - consumed_ext;
                    end
                    else
                    begin
                        job.last   = 1'b1;
                        phase_next = 1'b0;
                        hidx_next  = HDR_LEN0;
                    end
                end
                else
                begin
                    bbc_next = bbc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            hidx_reg   <= HDR_LEN0;
            is_pcm_reg <= 1'b0;
            rfl_reg    <= RFL_1X;
            rem_reg    <= '0;
            bbc_reg    <= '0;
            prior_reg  <= 16'sd0;
            low_reg    <= 8'd0;
            held_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            is_pcm_reg <= is_pcm_next;
            rfl_reg    <= rfl_next;
            rem_reg    <= rem_next;
            bbc_reg    <= bbc_next;
            prior_reg  <= prior_next;
            low_reg    <= low_next;
            held_reg   <= held_next;
        end
    end

endmodule

@@ src/mlu_fifo.sv @@
// ----------------------------------------------------------------------------
// mlu_fifo
// Short job queue between the byte front end and the sample back end.
// ----------------------------------------------------------------------------
module mlu_fifo
    import mlu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  job_t    wr_job,
    input  logic    rd,
    output job_t    rd_job,
    output q_stat_t stat
);

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, wp_next;
    logic [Q_AW-1:0] rp_reg, rp_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_job     = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/mlu_back.sv @@
// ----------------------------------------------------------------------------
// mlu_back
// Sample back end: expands each job into its interpolated samples and the
// decoded sample, one per cycle into the output register when free or popped.
// ----------------------------------------------------------------------------
module mlu_back
    import mlu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  job_t               job,
    output logic               job_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] sample,
    output logic               last
);

    logic [1:0]         idx_reg, idx_next;
    logic               ov_reg, ov_next;
    logic signed [15:0] smp_reg, smp_next;
    logic               last_reg, last_next;

    logic               load;
    logic [1:0]         kind;
    logic               fin;
    logic signed [17:0] p18, s18, q1, mid, q3;

    assign empty  = !ov_reg;
    assign sample = smp_reg;
    assign last   = last_reg;

    assign load    = !q_stat.empty && (!ov_reg || pop);
    assign fin     = (kind == KIND_CUR);
    assign job_pop = load && fin;

    assign p18 = $signed({{2{job.prior[15]}}, job.prior});
    assign s18 = $signed({{2{job.cur[15]}}, job.cur});
    assign q1  = ((p18 <<< 1) + p18 + s18) >>> 2;
    assign mid = (p18 + s18) >>> 1;
    assign q3  = ((s18 <<< 1) + s18 + p18) >>> 2;

    always_comb
    begin
        case (job.rfl)
            RFL_1X:  kind = KIND_CUR;
            RFL_2X:  kind = idx_reg[0] ? KIND_CUR : KIND_MID;
            default: kind = idx_reg;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        smp_next  = smp_reg;
        last_next = last_reg;
        ov_next   = ov_reg && !pop;
        if (load)
        begin
            ov_next   = 1'b1;
            last_next = fin && job.last;
            idx_next  = fin ? 2'd0 : idx_reg + 2'd1;
            case (kind)
                KIND_Q1:  smp_next = q1[15:0];
                KIND_MID: smp_next = mid[15:0];
                KIND_Q3:  smp_next = q3[15:0];
                default:  smp_next = job.cur;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            ov_reg   <= 1'b0;
            smp_reg  <= 16'sd0;
            last_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
            smp_reg  <= smp_next;
            last_reg <= last_next;
        end
    end

endmodule

@@ src/mulaw_pcm_clip_upsampler.sv @@
// ----------------------------------------------------------------------------
// mulaw_pcm_clip_upsampler
// Clip byte stream player: 4-byte header, mu-law or 16-bit PCM decode,
// 1x/2x/4x linear-interpolation upsampling, block-based end of clip.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle while the 4-entry job queue has room;
// header bytes, PCM low bytes and stop items produce no samples. Each decoded
// sample yields 1, 2 or 4 output samples, and the back end writes one sample
// per cycle into the output register while it is empty or being popped.
// Mu-law at 2x and 4x is bound by the back end; PCM at 1x is bound by its
// two input bytes per sample. The output sample register decouples result
// pop from input push; last marks the final sample of the clip.
module mulaw_pcm_clip_upsampler
    import mlu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic [7:0]         data_byte,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample,
    output logic               last
);

    q_stat_t q_stat;
    logic    job_push;
    logic    job_pop;
    job_t    wr_job;
    job_t    rd_job;

    mlu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .op        (op),
        .data_byte (data_byte),
        .full      (full),
        .q_stat    (q_stat),
        .job_push  (job_push),
        .job       (wr_job)
    );

    mlu_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (wr_job),
        .rd     (job_pop),
        .rd_job (rd_job),
        .stat   (q_stat)
    );

    mlu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .job     (rd_job),
        .job_pop (job_pop),
        .pop     (pop),
        .empty   (empty),
        .sample  (sample),
        .last    (last)
    );

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_stat.full)
        else $error("job written into full queue");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !q_stat.empty)
        else $error("job read from empty queue");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_out_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && empty) |=> !empty)
        else $error("output register not loaded from waiting job");

endmodule
